[src/fpfw_pkg.sv]
// Shared types, constants and color conversion helpers for the pixel format writer.
`default_nettype none

package fpfw_pkg;

  localparam int MAX_DIM_DEF = 4096;

  // Field widths fixed by the register map and the stream payload
  localparam int AREA_W    = 13;
  localparam int LINE_W    = 16;
  localparam int BPP_W     = 6;
  localparam int FMT_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int PIX_W     = 32;
  localparam int OFF_W     = 30;
  // origin plus counter never exceeds 2*8191
  localparam int POS_W     = AREA_W + 1;
  localparam int PX_W      = POS_W + 3;
  localparam int DIM_CMP_W = AREA_W + 1;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [BPP_W-1:0] BPP_16 = BPP_W'(16);
  localparam logic [BPP_W-1:0] BPP_32 = BPP_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_AREA_WIDTH  = 3'd2,
    REG_AREA_HEIGHT = 3'd3,
    REG_FB_STRIDE   = 3'd4,
    REG_FB_BPP      = 3'd5,
    REG_SRC_FORMAT  = 3'd6
  } reg_idx_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB565   = 2'd0,
    FMT_RGB888   = 2'd1,
    FMT_XRGB8888 = 2'd2,
    FMT_OTHER    = 2'd3
  } src_fmt_t;

  // What the back end does with a pixel
  typedef enum logic [2:0] {
    KIND_RAW16    = 3'd0,
    KIND_EXPAND32 = 3'd1,
    KIND_PACK16   = 3'd2,
    KIND_PASS32   = 3'd3,
    KIND_DROP     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [AREA_W-1:0] origin_x;
    logic [AREA_W-1:0] origin_y;
    logic [AREA_W-1:0] area_width;
    logic [AREA_W-1:0] area_height;
    logic [LINE_W-1:0] fb_stride;
    logic [BPP_W-1:0]  fb_bpp;
    logic [FMT_W-1:0]  source_format;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] xpos;
    logic [POS_W-1:0] ypos;
    logic [PIX_W-1:0] pixel;
    kind_t            kind;
    logic             last;
  } entry_t;

  // c*255/31 truncated: 8c + floor(7c/31), the small quotient by reciprocal 529/2^14
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [7:0]  m;
    logic [16:0] t;
    m = 8'(c) * 8'd7;
    t = 17'(m) * 17'd529;
    return {c, 3'b000} + 8'(t[16:14]);
  endfunction

  // c*255/63 truncated: 4c + floor(c/21)
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [1:0] q;
    q = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
    return {c, 2'b00} + 8'(q);
  endfunction

  function automatic logic [15:0] pack888(input logic [PIX_W-1:0] v);
    return {v[23:19], v[15:10], v[7:3]};
  endfunction

endpackage

`default_nettype wire

[src/fpfw_front.sv]
// Front end: accepts source pixels, tracks the area position and classifies the conversion.
`default_nettype none

module fpfw_front #(
  parameter int MAX_DIM = fpfw_pkg::MAX_DIM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fpfw_pkg::cfg_t              cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [fpfw_pkg::PIX_W-1:0]  in_pixel,
  output logic                             push,
  output fpfw_pkg::entry_t                 push_entry,
  input  wire logic                        queue_ready
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = CNT_W + 1;

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic [DIM_W-1:0] w, h;
  logic             last;
  logic [fpfw_pkg::PIX_W-1:0] swapped;

  assign in_ready = queue_ready;
  assign push     = in_valid && queue_ready;

  // zero counts as one, oversize saturates
  always_comb begin
    if (cfg.area_width == '0) begin
      w = DIM_W'(1);
    end else if ({1'b0, cfg.area_width} > fpfw_pkg::DIM_CMP_W'(MAX_DIM)) begin
      w = DIM_W'(MAX_DIM);
    end else begin
      w = DIM_W'(cfg.area_width);
    end
    if (cfg.area_height == '0) begin
      h = DIM_W'(1);
    end else if ({1'b0, cfg.area_height} > fpfw_pkg::DIM_CMP_W'(MAX_DIM)) begin
      h = DIM_W'(MAX_DIM);
    end else begin
      h = DIM_W'(cfg.area_height);
    end
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    last              = 1'b0;
    if ((DIM_W'(column_count) + DIM_W'(1)) >= w) begin
      column_count_next = '0;
      if ((DIM_W'(row_count) + DIM_W'(1)) >= h) begin
        row_count_next = '0;
        last           = 1'b1;
      end else begin
        row_count_next = row_count + CNT_W'(1);
      end
    end else begin
      column_count_next = column_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // byte 0 red -> red in bits 23:16
  assign swapped = {8'h00, in_pixel[7:0], in_pixel[15:8], in_pixel[23:16]};

  always_comb begin
    push_entry.xpos = fpfw_pkg::POS_W'(cfg.origin_x) + fpfw_pkg::POS_W'(column_count);
    push_entry.ypos = fpfw_pkg::POS_W'(cfg.origin_y) + fpfw_pkg::POS_W'(row_count);
    push_entry.last = last;
    push_entry.pixel = {16'h0000, in_pixel[15:0]};
    push_entry.kind  = fpfw_pkg::KIND_RAW16;
    case (fpfw_pkg::src_fmt_t'(cfg.source_format))
      fpfw_pkg::FMT_RGB888, fpfw_pkg::FMT_XRGB8888: begin
        push_entry.pixel = (cfg.source_format == fpfw_pkg::FMT_RGB888) ? swapped : in_pixel;
        if (cfg.fb_bpp == fpfw_pkg::BPP_32) begin
          push_entry.kind = fpfw_pkg::KIND_PASS32;
        end else if (cfg.fb_bpp == fpfw_pkg::BPP_16) begin
          push_entry.kind = fpfw_pkg::KIND_PACK16;
        end else begin
          push_entry.kind = fpfw_pkg::KIND_DROP;
        end
      end
      default: begin
        if (cfg.fb_bpp == fpfw_pkg::BPP_32) begin
          push_entry.kind = fpfw_pkg::KIND_EXPAND32;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[src/fpfw_fifo.sv]
// Two-entry queue between the front end and the back end.
`default_nettype none

module fpfw_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire fpfw_pkg::entry_t push_entry,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic                  pop_valid,
  output fpfw_pkg::entry_t      pop_entry
);

  fpfw_pkg::entry_t                    slots [fpfw_pkg::FIFO_DEPTH];
  logic [fpfw_pkg::FIFO_PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [fpfw_pkg::FIFO_CNT_W-1:0]     count;
  logic                                do_push, do_pop;

  assign push_ready = (count != fpfw_pkg::FIFO_CNT_W'(fpfw_pkg::FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + fpfw_pkg::FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + fpfw_pkg::FIFO_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + fpfw_pkg::FIFO_CNT_W'(1);
        2'b01:   count <= count - fpfw_pkg::FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/fpfw_back.sv]
// Back end: offset multiplies and color conversion, then offset sum into the output register.
`default_nettype none

module fpfw_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fpfw_pkg::cfg_t              cfg,
  input  wire logic                        q_valid,
  input  wire fpfw_pkg::entry_t            q_entry,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [fpfw_pkg::OFF_W-1:0]       byte_offset,
  output logic [fpfw_pkg::PIX_W-1:0]       write_data,
  output logic                             write_wide,
  output logic                             write_enable,
  output logic                             last_pixel
);

  logic                           s1_valid;
  logic [fpfw_pkg::PX_W-1:0]      s1_prod_x;
  logic [fpfw_pkg::OFF_W-1:0]     s1_prod_y;
  logic [fpfw_pkg::PIX_W-1:0]     s1_data;
  logic                           s1_wide, s1_enable, s1_last;
  logic                           adv1, adv2;
  logic [fpfw_pkg::PIX_W-1:0]     conv_data;
  logic                           conv_wide, conv_enable;

  // whole pipe moves when the output register frees up; an empty stage 1 still loads
  assign adv2  = !out_valid || out_ready;
  assign adv1  = !s1_valid || adv2;
  assign q_pop = q_valid && adv1;

  always_comb begin
    conv_data   = '0;
    conv_wide   = 1'b0;
    conv_enable = 1'b1;
    case (q_entry.kind)
      fpfw_pkg::KIND_RAW16: begin
        conv_data = {16'h0000, q_entry.pixel[15:0]};
      end
      fpfw_pkg::KIND_EXPAND32: begin
        conv_data = {8'h00, fpfw_pkg::expand5(q_entry.pixel[15:11]),
                     fpfw_pkg::expand6(q_entry.pixel[10:5]),
                     fpfw_pkg::expand5(q_entry.pixel[4:0])};
        conv_wide = 1'b1;
      end
      fpfw_pkg::KIND_PACK16: begin
        conv_data = {16'h0000, fpfw_pkg::pack888(q_entry.pixel)};
      end
      fpfw_pkg::KIND_PASS32: begin
        conv_data = q_entry.pixel;
        conv_wide = 1'b1;
      end
      default: begin
        conv_enable = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= q_valid;
      end
      if (adv2) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_prod_x <= fpfw_pkg::PX_W'(q_entry.xpos) * fpfw_pkg::PX_W'(cfg.fb_bpp[5:3]);
      s1_prod_y <= fpfw_pkg::OFF_W'(q_entry.ypos) * fpfw_pkg::OFF_W'(cfg.fb_stride);
      s1_data   <= conv_data;
      s1_wide   <= conv_wide;
      s1_enable <= conv_enable;
      s1_last   <= q_entry.last;
    end
    if (adv2) begin
      // sum wraps at 2^30
      byte_offset  <= s1_prod_y + fpfw_pkg::OFF_W'(s1_prod_x);
      write_data   <= s1_data;
      write_wide   <= s1_wide;
      write_enable <= s1_enable;
      last_pixel   <= s1_last;
    end
  end

endmodule

`default_nettype wire

[src/framebuffer_pixel_format_writer_top.sv]
// Top level of the framebuffer pixel format writer: register file, front end, queue, back end.
`default_nettype none

// Streams the source pixels of a rectangle in raster order and returns, per pixel, the
// framebuffer byte offset, the converted data word, the store size and a write enable.
// Sustained rate is one pixel per clock while m_axis_tready holds; a result passes from the
// queue entry through the back end's multiply stage into the output register, and stays
// there until taken. The column and row counters advance on each accepted transfer, so
// the next pixel can be taken in the following cycle. The user must write registers only
// while no pixel is in flight; the block itself does not enforce it. After the last pixel
// of an area the counters are back at zero for the next area.
module framebuffer_pixel_format_writer_top #(
  parameter int MAX_DIM = fpfw_pkg::MAX_DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [fpfw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fpfw_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [31:0]                       s_axis_tdata,  // [31:0] src_pixel
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [63:0]                            m_axis_tdata,  // [29:0] byte_offset,
                                                                // [61:30] write_data, zero pad
  output logic [1:0]                             m_axis_tuser,  // [0] write_wide,
                                                                // [1] write_enable
  output logic                                   m_axis_tlast
);

  fpfw_pkg::cfg_t    cfg;
  logic              push, push_ready, q_valid, q_pop;
  fpfw_pkg::entry_t  push_entry, q_entry;
  logic [fpfw_pkg::OFF_W-1:0] byte_offset;
  logic [fpfw_pkg::PIX_W-1:0] write_data;
  logic              write_wide, write_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.area_width    <= fpfw_pkg::AREA_W'(1);
      cfg.area_height   <= fpfw_pkg::AREA_W'(1);
      cfg.fb_stride     <= '0;
      cfg.fb_bpp        <= fpfw_pkg::BPP_16;
      cfg.source_format <= fpfw_pkg::FMT_RGB565;
    end else if (cfg_we) begin
      case (fpfw_pkg::reg_idx_t'(cfg_index))
        fpfw_pkg::REG_ORIGIN_X:    cfg.origin_x      <= cfg_data[fpfw_pkg::AREA_W-1:0];
        fpfw_pkg::REG_ORIGIN_Y:    cfg.origin_y      <= cfg_data[fpfw_pkg::AREA_W-1:0];
        fpfw_pkg::REG_AREA_WIDTH:  cfg.area_width    <= cfg_data[fpfw_pkg::AREA_W-1:0];
        fpfw_pkg::REG_AREA_HEIGHT: cfg.area_height   <= cfg_data[fpfw_pkg::AREA_W-1:0];
        fpfw_pkg::REG_FB_STRIDE:   cfg.fb_stride     <= cfg_data[fpfw_pkg::LINE_W-1:0];
        fpfw_pkg::REG_FB_BPP:      cfg.fb_bpp        <= cfg_data[fpfw_pkg::BPP_W-1:0];
        fpfw_pkg::REG_SRC_FORMAT:  cfg.source_format <= cfg_data[fpfw_pkg::FMT_W-1:0];
        default: ;
      endcase
    end
  end

  fpfw_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_pixel    (s_axis_tdata),
    .push        (push),
    .push_entry  (push_entry),
    .queue_ready (push_ready)
  );

  fpfw_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  fpfw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .byte_offset  (byte_offset),
    .write_data   (write_data),
    .write_wide   (write_wide),
    .write_enable (write_enable),
    .last_pixel   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, write_data, byte_offset};
  assign m_axis_tuser = {write_enable, write_wide};

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the framebuffer pixel format writer top level.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 1300;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [29:0] byte_offset;
    logic [31:0] write_data;
    logic        write_wide;
    logic        write_enable;
    logic        last_pixel;
  } fb_write_t;

  // one row of the directed sequence: a register write or a pixel
  typedef struct {
    bit                 is_reg;
    fpfw_pkg::reg_idx_t idx;
    logic [15:0]        value;
    logic [31:0]        pixel;
    bit                 typed;
    fb_write_t          want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  framebuffer_pixel_format_writer_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register shadow and area position
  logic [12:0]        reg_origin_x = '0;
  logic [12:0]        reg_origin_y = '0;
  logic [12:0]        reg_area_width = 13'd1;
  logic [12:0]        reg_area_height = 13'd1;
  logic [15:0]        reg_fb_stride = '0;
  logic [5:0]         reg_bpp = 6'd16;
  fpfw_pkg::src_fmt_t reg_format = fpfw_pkg::FMT_RGB565;
  int unsigned        col_count = 0;
  int unsigned        row_count = 0;

  fb_write_t    pending_writes[$];
  step_t        directed_steps[$];
  int           errors = 0;
  int           pixels_sent = 0;
  int           writes_checked = 0;
  int           areas_done = 0;
  int           reg_writes = 0;
  int           phases = 0;
  bit           cfg_open = 1'b0;
  bit           tx_calm = 1'b1;
  bit           rx_calm = 1'b1;
  int           rx_hold = 0;

  function automatic int unsigned clamp_dim(logic [12:0] v);
    if (v == 0) return 1;
    if (v > fpfw_pkg::MAX_DIM_DEF) return fpfw_pkg::MAX_DIM_DEF;
    return v;
  endfunction

  // Expected store for one pixel; advances the area position.
  function automatic fb_write_t convert_pixel(logic [31:0] px);
    fb_write_t   r;
    logic [31:0] rgb;
    logic [63:0] off;
    int unsigned w, h, rr, gg, bb;
    w = clamp_dim(reg_area_width);
    h = clamp_dim(reg_area_height);
    off = (64'(reg_origin_x) + 64'(col_count)) * 64'(reg_bpp >> 3)
        + (64'(reg_origin_y) + 64'(row_count)) * 64'(reg_fb_stride);
    r = '0;
    r.byte_offset = off[29:0];
    r.write_enable = 1'b1;
    if (reg_format == fpfw_pkg::FMT_RGB888 || reg_format == fpfw_pkg::FMT_XRGB8888) begin
      // byte 0 is red in 888 source
      rgb = (reg_format == fpfw_pkg::FMT_RGB888) ? {8'h00, px[7:0], px[15:8], px[23:16]} : px;
      if (reg_bpp == fpfw_pkg::BPP_32) begin
        r.write_data = rgb;
        r.write_wide = 1'b1;
      end else if (reg_bpp == fpfw_pkg::BPP_16) begin
        r.write_data = {16'h0000, rgb[23:19], rgb[15:10], rgb[7:3]};
      end else begin
        r.write_enable = 1'b0;
      end
    end else begin
      if (reg_bpp == fpfw_pkg::BPP_32) begin
        rr = (int'(px[15:11]) * 255) / 31;
        gg = (int'(px[10:5]) * 255) / 63;
        bb = (int'(px[4:0]) * 255) / 31;
        r.write_data = {8'h00, 8'(rr), 8'(gg), 8'(bb)};
        r.write_wide = 1'b1;
      end else begin
        r.write_data = {16'h0000, px[15:0]};
      end
    end
    // counters past a shrunk area end the row (and area) at once
    if (col_count + 1 >= w) begin
      col_count = 0;
      if (row_count + 1 >= h) begin
        row_count = 0;
        r.last_pixel = 1'b1;
      end else begin
        row_count++;
      end
    end else begin
      col_count++;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // output side: check every transfer, stall at random
  always @(posedge clk) begin
    fb_write_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h user %b last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        check_field("byte_offset", 32'(want.byte_offset), 32'(m_axis_tdata[29:0]));
        check_field("write_data", want.write_data, m_axis_tdata[61:30]);
        check_field("write_wide", 32'(want.write_wide), 32'(m_axis_tuser[0]));
        check_field("write_enable", 32'(want.write_enable), 32'(m_axis_tuser[1]));
        check_field("last_pixel", 32'(want.last_pixel), 32'(m_axis_tlast));
        writes_checked++;
        if (want.last_pixel) areas_done++;
      end
    end
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 3) == 0)
        rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if ($urandom_range(0, 299) == 0) rx_calm <= ~rx_calm;
  end

  function automatic int tx_gap();
    if ($urandom_range(0, 149) == 0) tx_calm = ~tx_calm;
    if (tx_calm || $urandom_range(0, 1) == 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // drop valid and let every result in flight come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  task automatic write_reg(fpfw_pkg::reg_idx_t idx, logic [15:0] value);
    if (!cfg_open) wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_open = 1'b1;
    reg_writes++;
    case (idx)
      fpfw_pkg::REG_ORIGIN_X:    reg_origin_x = value[12:0];
      fpfw_pkg::REG_ORIGIN_Y:    reg_origin_y = value[12:0];
      fpfw_pkg::REG_AREA_WIDTH:  reg_area_width = value[12:0];
      fpfw_pkg::REG_AREA_HEIGHT: reg_area_height = value[12:0];
      fpfw_pkg::REG_FB_STRIDE:   reg_fb_stride = value;
      fpfw_pkg::REG_FB_BPP:      reg_bpp = value[5:0];
      fpfw_pkg::REG_SRC_FORMAT:  reg_format = fpfw_pkg::src_fmt_t'(value[1:0]);
      default: ;
    endcase
  endtask

  task automatic send_pixel(logic [31:0] px, bit typed, fb_write_t typed_want);
    fb_write_t predicted;
    int        gap;
    if (cfg_open) begin
      cfg_we <= 1'b0;
      cfg_open = 1'b0;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk); while (!s_axis_tready);
    predicted = convert_pixel(px);
    pending_writes.push_back(typed ? typed_want : predicted);
    pixels_sent++;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void add_reg(fpfw_pkg::reg_idx_t idx, logic [15:0] value);
    step_t s;
    s = '{is_reg: 1'b1, idx: idx, value: value, pixel: '0, typed: 1'b0, want: '0};
    directed_steps.push_back(s);
  endfunction

  function automatic void add_pixel(logic [31:0] px);
    step_t s;
    s = '{is_reg: 1'b0, idx: fpfw_pkg::REG_ORIGIN_X, value: '0, pixel: px, typed: 1'b0,
          want: '0};
    directed_steps.push_back(s);
  endfunction

  function automatic void add_typed(logic [31:0] px, logic [29:0] off, logic [31:0] data,
                                    logic wide, logic en, logic last);
    step_t s;
    s = '{is_reg: 1'b0, idx: fpfw_pkg::REG_ORIGIN_X, value: '0, pixel: px, typed: 1'b1,
          want: '{off, data, wide, en, last}};
    directed_steps.push_back(s);
  endfunction

  function automatic logic [15:0] pick_origin();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd8191;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, 8191));
    endcase
  endfunction

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             LIMIT_CYCLES, pending_writes.size());
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int unsigned w, h, rem, n, sel;
    bit          first_phase;

    // defaults after reset: 1x1 area at 0, 16 bpp, 565 source
    add_typed(32'hFFFF_FFFF, 30'd0, 32'h0000_FFFF, 1'b0, 1'b1, 1'b1);
    add_typed(32'h0000_0000, 30'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b1);
    add_pixel(32'h1234_F81F);
    add_reg(fpfw_pkg::REG_FB_BPP, 16'd32);
    add_typed(32'h0000_FFFF, 30'd0, 32'h00FF_FFFF, 1'b1, 1'b1, 1'b1);
    add_typed(32'hFFFF_0000, 30'd0, 32'h0000_0000, 1'b1, 1'b1, 1'b1);
    add_pixel(32'h0000_0821);
    add_reg(fpfw_pkg::REG_SRC_FORMAT, 16'(fpfw_pkg::FMT_RGB888));
    add_typed(32'hFFFF_FFFF, 30'd0, 32'h00FF_FFFF, 1'b1, 1'b1, 1'b1);
    add_pixel(32'h0033_2211);
    add_reg(fpfw_pkg::REG_SRC_FORMAT, 16'(fpfw_pkg::FMT_XRGB8888));
    add_typed(32'hFFFF_FFFF, 30'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    add_reg(fpfw_pkg::REG_FB_BPP, 16'd16);
    add_typed(32'h00FF_FFFF, 30'd0, 32'h0000_FFFF, 1'b0, 1'b1, 1'b1);
    add_pixel(32'h00A5_C3E7);
    add_reg(fpfw_pkg::REG_SRC_FORMAT, 16'(fpfw_pkg::FMT_RGB888));
    add_pixel(32'h00E7_C3A5);
    // unsupported depth with a 24/32-bit source: no store
    add_reg(fpfw_pkg::REG_FB_BPP, 16'd8);
    add_typed(32'hFFFF_FFFF, 30'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
    add_reg(fpfw_pkg::REG_SRC_FORMAT, 16'(fpfw_pkg::FMT_OTHER));
    add_typed(32'hABCD_1234, 30'd0, 32'h0000_1234, 1'b0, 1'b1, 1'b1);
    add_reg(fpfw_pkg::REG_FB_BPP, 16'hFFFF);
    add_pixel(32'h5A5A_5A5A);
    // far corner of the framebuffer, 2x2 area
    add_reg(fpfw_pkg::REG_ORIGIN_X, 16'hFFFF);
    add_reg(fpfw_pkg::REG_ORIGIN_Y, 16'h1FFF);
    add_reg(fpfw_pkg::REG_FB_STRIDE, 16'hFFFF);
    add_reg(fpfw_pkg::REG_FB_BPP, 16'd32);
    add_reg(fpfw_pkg::REG_SRC_FORMAT, 16'(fpfw_pkg::FMT_RGB565));
    add_reg(fpfw_pkg::REG_AREA_WIDTH, 16'd2);
    add_reg(fpfw_pkg::REG_AREA_HEIGHT, 16'd2);
    add_pixel(32'h0000_F800);
    add_pixel(32'h0000_07E0);
    add_pixel(32'h0000_001F);
    add_pixel(32'hFFFF_FFFF);
    // 4x3 area, stop mid-row 1, then shrink below the current position
    add_reg(fpfw_pkg::REG_AREA_WIDTH, 16'd4);
    add_reg(fpfw_pkg::REG_AREA_HEIGHT, 16'd3);
    for (int i = 0; i < 7; i++) add_pixel(32'h1111_1111 * (i + 1));
    add_reg(fpfw_pkg::REG_AREA_WIDTH, 16'd2);
    add_reg(fpfw_pkg::REG_AREA_HEIGHT, 16'd1);
    add_pixel(32'hC3C3_3C3C);
    // zero size acts as 1, oversize saturates
    add_reg(fpfw_pkg::REG_AREA_WIDTH, 16'd0);
    add_reg(fpfw_pkg::REG_AREA_HEIGHT, 16'd0);
    add_pixel(32'h8000_0001);
    add_reg(fpfw_pkg::REG_AREA_WIDTH, 16'hFFFF);
    add_reg(fpfw_pkg::REG_AREA_HEIGHT, 16'd2);
    add_pixel(32'h7FFF_FFFE);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_reg)
        write_reg(directed_steps[i].idx, directed_steps[i].value);
      else
        send_pixel(directed_steps[i].pixel, directed_steps[i].typed, directed_steps[i].want);
    end

    first_phase = 1'b1;
    while (pixels_sent < directed_steps.size() + RANDOM_ITEMS) begin
      if (first_phase || $urandom_range(0, 1))
        write_reg(fpfw_pkg::REG_ORIGIN_X, pick_origin());
      if (first_phase || $urandom_range(0, 1))
        write_reg(fpfw_pkg::REG_ORIGIN_Y, pick_origin());
      if (first_phase || $urandom_range(0, 2) != 0) begin
        sel = $urandom_range(0, 19);
        if (sel < 15) begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 8);
        end else if (sel < 18) begin
          w = $urandom_range(9, 64);
          h = $urandom_range(1, 3);
        end else if (sel == 18) begin
          case ($urandom_range(0, 2))
            0: w = 0;
            1: w = 16'hFFFF;
            default: w = fpfw_pkg::MAX_DIM_DEF;
          endcase
          h = $urandom_range(0, 2);
        end else begin
          w = $urandom_range(1, 4);
          h = $urandom_range(0, 1) ? 0 : 16'hFFFF;
        end
        write_reg(fpfw_pkg::REG_AREA_WIDTH, 16'(w));
        write_reg(fpfw_pkg::REG_AREA_HEIGHT, 16'(h));
      end
      if (first_phase || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0: write_reg(fpfw_pkg::REG_FB_STRIDE, 16'd0);
          1: write_reg(fpfw_pkg::REG_FB_STRIDE, 16'hFFFF);
          default: write_reg(fpfw_pkg::REG_FB_STRIDE, 16'($urandom));
        endcase
      end
      if (first_phase || $urandom_range(0, 1)) begin
        sel = $urandom_range(0, 9);
        if (sel < 4)       write_reg(fpfw_pkg::REG_FB_BPP, 16'd16);
        else if (sel < 8)  write_reg(fpfw_pkg::REG_FB_BPP, 16'd32);
        else if (sel == 8) write_reg(fpfw_pkg::REG_FB_BPP, 16'($urandom_range(0, 63)));
        else               write_reg(fpfw_pkg::REG_FB_BPP, 16'($urandom));
      end
      if (first_phase || $urandom_range(0, 1))
        write_reg(fpfw_pkg::REG_SRC_FORMAT, 16'($urandom_range(0, 3)));
      first_phase = 1'b0;

      // mostly whole areas from the current position; some cut short
      w = clamp_dim(reg_area_width);
      h = clamp_dim(reg_area_height);
      if (col_count < w && row_count < h)
        rem = (h - 1 - row_count) * w + (w - col_count);
      else
        rem = $urandom_range(1, 8);
      if (rem > 300)
        n = $urandom_range(1, 60);
      else if ($urandom_range(0, 4) != 0)
        n = rem + w * h * $urandom_range(0, 2);
      else
        n = $urandom_range(1, rem);
      if (n > 400) n = rem;
      if (n > directed_steps.size() + RANDOM_ITEMS - pixels_sent)
        n = directed_steps.size() + RANDOM_ITEMS - pixels_sent;
      repeat (n) send_pixel($urandom, 1'b0, '0);
      phases++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d pixels over %0d register settings (%0d writes), %0d results",
             pixels_sent, phases, reg_writes, writes_checked);
    $display("summary: %0d areas completed, all formats and depths, stalls on both sides",
             areas_done);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
